### rtl/core/serial_command_valve_timer_macros.svh
// Assertion macros shared by the valve timer RTL.
`ifndef SERIAL_COMMAND_VALVE_TIMER_MACROS_SVH
`define SERIAL_COMMAND_VALVE_TIMER_MACROS_SVH

// Same-cycle implication, checked on every edge out of reset.
`define SCVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/scvt_pkg.sv
// Constants and types for the serial command valve timer.
`timescale 1ns / 1ps

package scvt_pkg;

    // Item kinds
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_IDLE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Frame layout
    localparam int STATUS_POS = 8;
    localparam int FLAG_POS   = 16;
    localparam int FLAG_NUM   = 4;
    localparam int LIMIT_POS  = 20;
    localparam int LIMIT_NUM  = 3;

    localparam int LIMIT_W = 11;
    localparam int PERIOD_W = 16;

    localparam logic [PERIOD_W-1:0]       PERIOD_RST = 16'd10;
    localparam logic signed [LIMIT_W-1:0] LIMIT_RST  = 11'sd20;

    typedef struct packed {
        logic [FLAG_NUM-1:0] relay_bits;
        logic                valve_mode;
        logic                report_due;
        logic                frame_parsed;
    } result_t;

endpackage

### rtl/core/serial_command_valve_timer.sv
// Relay valve controller: frame collection, parse, valve timing and report requests.
`timescale 1ns / 1ps

// Takes one word per clock while in_stall is low: the state update happens at
// the accepting edge and the result word is registered into the output queue.
// A two-entry output queue sits between the two sides; in_stall rises only
// when both entries hold words that have not been taken, so the block keeps
// accepting while a single result waits. Sustained rate is one item per cycle
// while out_stall lets words drain, set by the combinational state update path.
module serial_command_valve_timer #(
    parameter int FRAME_MIN = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [scvt_pkg::FLAG_NUM-1:0]     relay_bits,
    output logic                              valve_mode,
    output logic                              report_due,
    output logic                              frame_parsed,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scvt_pkg::PERIOD_W-1:0]     cfg_data
);
    import scvt_pkg::*;

    `include "serial_command_valve_timer_macros.svh"

    localparam int CNT_W = $clog2(FRAME_MIN + 1);
    localparam logic [CNT_W-1:0] FRAME_FULL = CNT_W'(FRAME_MIN);
    localparam int OPEN_W = LIMIT_W;

    // Control state
    logic                     mode_reg, mode_next;
    logic [CNT_W-1:0]         frame_count_reg, frame_count_next;
    logic [PERIOD_W-1:0]      report_timer_reg, report_timer_next;
    logic [PERIOD_W-1:0]      report_period_reg;
    logic signed [LIMIT_W-1:0] open_limit_reg, open_limit_next;
    logic [OPEN_W-1:0]        open_count_reg, open_count_next;
    logic [FLAG_NUM-1:0]      relays_reg, relays_next;

    // Frame capture, written before it is read
    logic [7:0]               status_char_reg, status_char_next;
    logic [FLAG_NUM-1:0]      valve_flags_reg, valve_flags_next;
    logic [8*LIMIT_NUM-1:0]   limit_chars_reg, limit_chars_next;

    // Output queue
    logic [1:0]               cnt_reg, cnt_next;
    result_t                  slot0_reg, slot0_next;
    result_t                  slot1_reg, slot1_next;

    logic                     push;
    logic                     pop;
    logic                     due;
    logic                     parsed;
    logic [PERIOD_W-1:0]      timer_inc;
    result_t                  res;

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    endfunction

    // Leading blanks, optional sign, then digits up to the first non-digit.
    function automatic logic signed [LIMIT_W-1:0] parse_limit(
        input logic [8*LIMIT_NUM-1:0] chars
    );
        logic [7:0]         ch;
        logic               skipping;
        logic               running;
        logic               neg;
        logic [LIMIT_W-2:0] val;
        logic [LIMIT_W-2:0] dig;
        skipping = 1'b1;
        running  = 1'b0;
        neg      = 1'b0;
        val      = '0;
        for (int i = 0; i < LIMIT_NUM; i++) begin
            ch  = chars[8*i +: 8];
            dig = (LIMIT_W-1)'(ch - CHAR_ZERO);
            if (skipping) begin
                if (!is_blank(ch)) begin
                    skipping = 1'b0;
                    if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
                        neg     = (ch == CHAR_MINUS);
                        running = 1'b1;
                    end else if (is_digit(ch)) begin
                        val     = dig;
                        running = 1'b1;
                    end
                end
            end else if (running) begin
                if (is_digit(ch)) begin
                    val = (val << 3) + (val << 1) + dig;
                end else begin
                    running = 1'b0;
                end
            end
        end
        return neg ? -$signed({1'b0, val}) : $signed({1'b0, val});
    endfunction

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    assign relay_bits   = slot0_reg.relay_bits;
    assign valve_mode   = slot0_reg.valve_mode;
    assign report_due   = slot0_reg.report_due;
    assign frame_parsed = slot0_reg.frame_parsed;

    assign timer_inc = (report_timer_reg == '1) ? report_timer_reg
                                                : report_timer_reg + 1'b1;

    always_comb
    begin
        mode_next         = mode_reg;
        frame_count_next  = frame_count_reg;
        report_timer_next = report_timer_reg;
        open_limit_next   = open_limit_reg;
        open_count_next   = open_count_reg;
        relays_next       = relays_reg;
        status_char_next  = status_char_reg;
        valve_flags_next  = valve_flags_reg;
        limit_chars_next  = limit_chars_reg;
        due               = 1'b0;
        parsed            = 1'b0;

        case (cmd)
            CMD_BYTE:
            begin
                // Drop bytes in valve mode or once the count has saturated at FRAME_MIN.
                if (!mode_reg && frame_count_reg < FRAME_FULL) begin
                    if (frame_count_reg == CNT_W'(STATUS_POS)) begin
                        status_char_next = rx_byte;
                    end
                    for (int i = 0; i < FLAG_NUM; i++) begin
                        if (frame_count_reg == CNT_W'(FLAG_POS + i)) begin
                            valve_flags_next[i] = (rx_byte == CHAR_ONE);
                        end
                    end
                    for (int i = 0; i < LIMIT_NUM; i++) begin
                        if (frame_count_reg == CNT_W'(LIMIT_POS + i)) begin
                            limit_chars_next[8*i +: 8] = rx_byte;
                        end
                    end
                    frame_count_next = frame_count_reg + 1'b1;
                end
            end
            CMD_IDLE:
            begin
                if (!mode_reg && frame_count_reg >= FRAME_FULL) begin
                    frame_count_next = '0;
                    parsed           = 1'b1;
                    if (status_char_reg == CHAR_ONE && valve_flags_reg != '0) begin
                        mode_next       = 1'b1;
                        open_limit_next = parse_limit(limit_chars_reg);
                        relays_next     = relays_reg | valve_flags_reg;
                    end
                end
            end
            CMD_TICK:
            begin
                report_timer_next = timer_inc;
                if (!mode_reg) begin
                    if (timer_inc >= report_period_reg) begin
                        due               = 1'b1;
                        report_timer_next = '0;
                        frame_count_next  = '0;
                    end
                end else begin
                    frame_count_next = '0;
                    // Close valves once the count reaches the limit, else advance the count.
                    if ($signed({1'b0, open_count_reg}) >=
                        $signed({open_limit_reg[LIMIT_W-1], open_limit_reg})) begin
                        relays_next     = '0;
                        mode_next       = 1'b0;
                        open_count_next = OPEN_W'(1);
                    end else if (open_count_reg != '1) begin
                        open_count_next = open_count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.relay_bits   = relays_next;
        res.valve_mode   = mode_next;
        res.report_due   = due;
        res.frame_parsed = parsed;
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push) begin
                    slot0_next = res;
                    cnt_next   = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop) begin
                    slot0_next = res;
                end else if (push) begin
                    slot1_next = res;
                    cnt_next   = 2'd2;
                end else if (pop) begin
                    cnt_next = 2'd0;
                end
            end
            default:
            begin
                // Full: advance the second word to the head.
                if (pop) begin
                    slot0_next = slot1_reg;
                    cnt_next   = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg          <= 1'b0;
            frame_count_reg   <= '0;
            report_timer_reg  <= '0;
            report_period_reg <= PERIOD_RST;
            open_limit_reg    <= LIMIT_RST;
            open_count_reg    <= '0;
            relays_reg        <= '0;
            cnt_reg           <= 2'd0;
        end else begin
            if (push) begin
                mode_reg         <= mode_next;
                frame_count_reg  <= frame_count_next;
                report_timer_reg <= report_timer_next;
                open_limit_reg   <= open_limit_next;
                open_count_reg   <= open_count_next;
                relays_reg       <= relays_next;
            end
            if (cfg_valid && cfg_ready) begin
                report_period_reg <= cfg_data;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            status_char_reg <= status_char_next;
            valve_flags_reg <= valve_flags_next;
            limit_chars_reg <= limit_chars_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `SCVT_ASSERT_NOW(a_queue_depth, 1'b1, cnt_reg != 2'd3, "output queue count out of range")
    `SCVT_ASSERT_NOW(a_stall_has_word, in_stall, out_valid, "stall raised with no word held")
    `SCVT_ASSERT_NOW(a_relays_off_in_connect, !mode_reg, relays_reg == '0, "relay on in connect mode")
    `SCVT_ASSERT_NOW(a_frame_count_sat, 1'b1, frame_count_reg <= FRAME_FULL, "frame count past limit")
    `SCVT_ASSERT_NEXT(a_valve_entry_by_parse, push && !mode_reg && cmd != CMD_IDLE, !mode_reg, "valve mode entered without a parse")

endmodule
